FILE: hdl/kpe_pkg.sv
`timescale 1ns / 1ps
// Package: key codes, register indexes, reset values and key decode for keypad PIN entry.
package kpe_pkg;

  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned KeyWidth    = 4;
  localparam int unsigned PosWidth    = 2;
  localparam int unsigned PinDigits   = 4;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [KeyWidth-1:0] KEY_STAR  = 4'd10;
  localparam logic [KeyWidth-1:0] KEY_HASH  = 4'd11;
  localparam logic [KeyWidth-1:0] KEY_NONE  = 4'd15;
  localparam logic [KeyWidth-1:0] KEY_DIGIT_MAX = 4'd9;

  localparam logic [CfgIdxWidth-1:0] REG_REPEAT_GUARD = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_BEEP_KEY     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_BEEP_CLEAR   = 2'd2;

  localparam logic [CfgWidth-1:0] RST_REPEAT_GUARD = 16'd100;
  localparam logic [CfgWidth-1:0] RST_BEEP_KEY     = 16'd50;
  localparam logic [CfgWidth-1:0] RST_BEEP_CLEAR   = 16'd800;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_KEY  = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [1:0]          column;
    logic [2:0]          row;
  } req_t;

  typedef struct packed {
    logic [KeyWidth-1:0] key_code;
    logic                key_accepted;
    logic                pin_ready;
    logic [15:0]         pin_value;
    logic                beep_on;
    logic [PosWidth-1:0] entry_position;
  } rsp_t;

  // Map column and row to a key code; positions off the keypad give KEY_NONE.
  function automatic logic [KeyWidth-1:0] decode_key(input logic [1:0] column,
                                                      input logic [2:0] row);
    logic [KeyWidth-1:0] code;
    code = KEY_NONE;
    unique case ({column, row})
      {2'd1, 3'd1}: code = KEY_STAR;
      {2'd1, 3'd2}: code = 4'd7;
      {2'd1, 3'd3}: code = 4'd4;
      {2'd1, 3'd4}: code = 4'd1;
      {2'd2, 3'd1}: code = 4'd0;
      {2'd2, 3'd2}: code = 4'd8;
      {2'd2, 3'd3}: code = 4'd5;
      {2'd2, 3'd4}: code = 4'd2;
      {2'd3, 3'd1}: code = KEY_HASH;
      {2'd3, 3'd2}: code = 4'd9;
      {2'd3, 3'd3}: code = 4'd6;
      {2'd3, 3'd4}: code = 4'd3;
      default:      code = KEY_NONE;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/keypad_pin_entry_unit.sv
`timescale 1ns / 1ps
// Top level: keypad PIN entry with repeat guard, beep timers and four-digit buffer.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid/in_ready, cmd, column, row   | request in
//  out     | out_valid/out_ready, key and PIN info | result out
//  cfg     | cfg_we, cfg_index, cfg_wdata          | write only
//
// A request passes the input register, then decode and state update into the result
// register. One request per cycle sustained while results are taken.
// Reset (rst_n low, synchronous) restores register defaults and clears state.
// A held result stalls the input register; in_ready drops only then.
module keypad_pin_entry_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [1:0]                         in_column,
  input  logic [2:0]                         in_row,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [kpe_pkg::KeyWidth-1:0]       out_key_code,
  output logic                               out_key_accepted,
  output logic                               out_pin_ready,
  output logic [15:0]                        out_pin_value,
  output logic                               out_beep_on,
  output logic [kpe_pkg::PosWidth-1:0]       out_entry_position,
  input  logic                               cfg_we,
  input  logic [kpe_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [kpe_pkg::CfgWidth-1:0]       cfg_wdata
);

  logic [kpe_pkg::CfgWidth-1:0] guard_len_r, beep_key_r, beep_clear_r;

  logic           req_valid_r;
  kpe_pkg::req_t  req_r;
  logic           rsp_valid_r;
  kpe_pkg::rsp_t  rsp_r, rsp_nxt;
  logic           advance;

  logic [kpe_pkg::KeyWidth-1:0] last_key_r, last_key_nxt;
  logic [15:0]                  guard_r, guard_nxt;
  logic [15:0]                  beep_r, beep_nxt;
  logic [kpe_pkg::KeyWidth-1:0] digits_r [kpe_pkg::PinDigits];
  logic [kpe_pkg::KeyWidth-1:0] digits_nxt [kpe_pkg::PinDigits];
  logic [kpe_pkg::PosWidth-1:0] pos_r, pos_nxt;

  logic [kpe_pkg::KeyWidth-1:0] code;
  logic                         accept;

  assign advance  = req_valid_r && (!rsp_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_len_r  <= kpe_pkg::RST_REPEAT_GUARD;
      beep_key_r   <= kpe_pkg::RST_BEEP_KEY;
      beep_clear_r <= kpe_pkg::RST_BEEP_CLEAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpe_pkg::REG_REPEAT_GUARD: guard_len_r  <= cfg_wdata;
        kpe_pkg::REG_BEEP_KEY:     beep_key_r   <= cfg_wdata;
        kpe_pkg::REG_BEEP_CLEAR:   beep_clear_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= '{cmd: in_cmd, column: in_column, row: in_row};
    end
  end

  always_comb begin
    code         = kpe_pkg::decode_key(req_r.column, req_r.row);
    accept       = 1'b0;
    last_key_nxt = last_key_r;
    guard_nxt    = guard_r;
    beep_nxt     = beep_r;
    digits_nxt   = digits_r;
    pos_nxt      = pos_r;
    rsp_nxt      = '0;

    if (req_r.cmd == kpe_pkg::CMD_TICK) begin
      if (guard_r != 16'd0) guard_nxt = guard_r - 16'd1;
      if (beep_r != 16'd0)  beep_nxt  = beep_r - 16'd1;
      if (guard_nxt == 16'd0) last_key_nxt = kpe_pkg::KEY_NONE;
    end else begin
      rsp_nxt.key_code = code;
      accept = (code != kpe_pkg::KEY_NONE) &&
               !(guard_r != 16'd0 && last_key_r == code);
      if (accept) begin
        last_key_nxt = code;
        guard_nxt    = guard_len_r;
        beep_nxt     = beep_key_r;
        if (code <= kpe_pkg::KEY_DIGIT_MAX) begin
          digits_nxt[pos_r] = code;
          pos_nxt           = pos_r + 1'b1;
        end else begin
          digits_nxt = '{default: '0};
          pos_nxt    = '0;
          if (code == kpe_pkg::KEY_HASH) begin
            rsp_nxt.pin_ready = 1'b1;
            rsp_nxt.pin_value = {digits_r[0], digits_r[1], digits_r[2], digits_r[3]};
          end else begin
            beep_nxt = beep_clear_r;
          end
        end
      end
    end

    rsp_nxt.key_accepted   = accept;
    rsp_nxt.beep_on        = (beep_nxt != 16'd0);
    rsp_nxt.entry_position = pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_key_r  <= kpe_pkg::KEY_NONE;
      guard_r     <= '0;
      beep_r      <= '0;
      digits_r    <= '{default: '0};
      pos_r       <= '0;
      rsp_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        last_key_r <= last_key_nxt;
        guard_r    <= guard_nxt;
        beep_r     <= beep_nxt;
        digits_r   <= digits_nxt;
        pos_r      <= pos_nxt;
        rsp_valid_r <= 1'b1;
      end else if (out_ready) begin
        rsp_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid          = rsp_valid_r;
  assign out_key_code       = rsp_r.key_code;
  assign out_key_accepted   = rsp_r.key_accepted;
  assign out_pin_ready      = rsp_r.pin_ready;
  assign out_pin_value      = rsp_r.pin_value;
  assign out_beep_on        = rsp_r.beep_on;
  assign out_entry_position = rsp_r.entry_position;

  a_pin_from_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pin_ready |->
      out_key_accepted && out_key_code == kpe_pkg::KEY_HASH)
    else $error("PIN emitted without an accepted hash key");

  a_pin_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pin_ready |-> out_entry_position == '0)
    else $error("entry position not cleared after PIN");

  a_accept_valid_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_accepted |-> out_key_code != kpe_pkg::KEY_NONE)
    else $error("off-keypad press reported as accepted");

  a_accept_beeps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && accept && beep_key_r != '0 && beep_clear_r != '0 |=> beep_r != '0)
    else $error("accepted key did not start the beep timer");

  a_stall_only_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while result side is free");

endmodule

FILE: bench/tb_keypad_pin_entry_unit.sv
`timescale 1ns / 1ps
// Testbench for keypad_pin_entry_unit: directed and random requests checked against a predictor.
module tb_keypad_pin_entry_unit;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned MaxReports = 10;
  localparam logic [kpe_pkg::CfgIdxWidth-1:0] RegUnused = 2'd3;

  class pin_entry_scoreboard;
    logic [kpe_pkg::CfgWidth-1:0] guard_len;
    logic [kpe_pkg::CfgWidth-1:0] beep_len;
    logic [kpe_pkg::CfgWidth-1:0] clear_len;
    logic [kpe_pkg::KeyWidth-1:0] last_key;
    logic [15:0]                  guard_left;
    logic [15:0]                  beep_left;
    logic [3:0]                   digits[kpe_pkg::PinDigits];
    logic [kpe_pkg::PosWidth-1:0] slot;
    kpe_pkg::rsp_t                expected_q[$];
    int                           failures;

    function new();
      guard_len  = kpe_pkg::RST_REPEAT_GUARD;
      beep_len   = kpe_pkg::RST_BEEP_KEY;
      clear_len  = kpe_pkg::RST_BEEP_CLEAR;
      last_key   = kpe_pkg::KEY_NONE;
      guard_left = '0;
      beep_left  = '0;
      failures   = 0;
      clear_digits();
    endfunction

    function void clear_digits();
      for (int i = 0; i < kpe_pkg::PinDigits; i++) digits[i] = '0;
      slot = '0;
    endfunction

    function void write_register(logic [kpe_pkg::CfgIdxWidth-1:0] idx,
                                 logic [kpe_pkg::CfgWidth-1:0] value);
      case (idx)
        kpe_pkg::REG_REPEAT_GUARD: guard_len = value;
        kpe_pkg::REG_BEEP_KEY:     beep_len = value;
        kpe_pkg::REG_BEEP_CLEAR:   clear_len = value;
        default: ;
      endcase
    endfunction

    function logic [kpe_pkg::KeyWidth-1:0] key_at(logic [1:0] col, logic [2:0] row);
      logic [kpe_pkg::KeyWidth-1:0] code;
      code = kpe_pkg::KEY_NONE;
      case (col)
        2'd1: case (row)
          3'd1: code = kpe_pkg::KEY_STAR;
          3'd2: code = 4'd7;
          3'd3: code = 4'd4;
          3'd4: code = 4'd1;
          default: ;
        endcase
        2'd2: case (row)
          3'd1: code = 4'd0;
          3'd2: code = 4'd8;
          3'd3: code = 4'd5;
          3'd4: code = 4'd2;
          default: ;
        endcase
        2'd3: case (row)
          3'd1: code = kpe_pkg::KEY_HASH;
          3'd2: code = 4'd9;
          3'd3: code = 4'd6;
          3'd4: code = 4'd3;
          default: ;
        endcase
        default: ;
      endcase
      return code;
    endfunction

    function void note_request(logic cmd, logic [1:0] col, logic [2:0] row);
      kpe_pkg::rsp_t                want;
      logic [kpe_pkg::KeyWidth-1:0] code;
      want = '0;
      if (cmd == kpe_pkg::CMD_TICK) begin
        if (guard_left != 0) guard_left--;
        if (beep_left != 0) beep_left--;
        if (guard_left == 0) last_key = kpe_pkg::KEY_NONE;
      end else begin
        code = key_at(col, row);
        want.key_code = code;
        if (code != kpe_pkg::KEY_NONE && !(guard_left != 0 && last_key == code)) begin
          want.key_accepted = 1'b1;
          last_key   = code;
          guard_left = guard_len;
          beep_left  = beep_len;
          if (code <= kpe_pkg::KEY_DIGIT_MAX) begin
            digits[slot] = code;
            slot++;
          end else if (code == kpe_pkg::KEY_HASH) begin
            want.pin_ready = 1'b1;
            want.pin_value = {digits[0], digits[1], digits[2], digits[3]};
            clear_digits();
          end else begin
            clear_digits();
            beep_left = clear_len;
          end
        end
      end
      want.beep_on = (beep_left != 0);
      want.entry_position = slot;
      expected_q.push_back(want);
    endfunction

    function void check_result(kpe_pkg::rsp_t got);
      kpe_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("unexpected result: code=%0d acc=%0b rdy=%0b pin=%h beep=%0b pos=%0d",
                   got.key_code, got.key_accepted, got.pin_ready, got.pin_value,
                   got.beep_on, got.entry_position);
        return;
      end
      want = expected_q.pop_front();
      if (got.key_code != want.key_code || got.key_accepted != want.key_accepted ||
          got.pin_ready != want.pin_ready || got.pin_value != want.pin_value ||
          got.beep_on != want.beep_on || got.entry_position != want.entry_position) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("mismatch at %0t: expected code=%0d acc=%0b rdy=%0b pin=%h beep=%0b pos=%0d",
                   $realtime, want.key_code, want.key_accepted, want.pin_ready,
                   want.pin_value, want.beep_on, want.entry_position);
          $display("  got code=%0d acc=%0b rdy=%0b pin=%h beep=%0b pos=%0d",
                   got.key_code, got.key_accepted, got.pin_ready, got.pin_value,
                   got.beep_on, got.entry_position);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_cmd;
  logic [1:0]                      in_column;
  logic [2:0]                      in_row;
  logic                            out_valid;
  logic                            out_ready;
  logic [kpe_pkg::KeyWidth-1:0]    out_key_code;
  logic                            out_key_accepted;
  logic                            out_pin_ready;
  logic [15:0]                     out_pin_value;
  logic                            out_beep_on;
  logic [kpe_pkg::PosWidth-1:0]    out_entry_position;
  logic                            cfg_we;
  logic [kpe_pkg::CfgIdxWidth-1:0] cfg_index;
  logic [kpe_pkg::CfgWidth-1:0]    cfg_wdata;

  pin_entry_scoreboard pin_sb;
  bit                  steady_flow;
  int                  hold_requests;
  int                  idle_cycles;
  logic [1:0]          prev_col;
  logic [2:0]          prev_row;

  keypad_pin_entry_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_column          (in_column),
    .in_row             (in_row),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_key_code       (out_key_code),
    .out_key_accepted   (out_key_accepted),
    .out_pin_ready      (out_pin_ready),
    .out_pin_value      (out_pin_value),
    .out_beep_on        (out_beep_on),
    .out_entry_position (out_entry_position),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready = 1'b0;
      end else if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (hold_requests > holds_served) begin
        holds_served++;
        hold_left = HoldOffCycles - 1;
        out_ready = 1'b0;
      end else begin
        out_ready = steady_flow || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      pin_sb.check_result('{key_code: out_key_code, key_accepted: out_key_accepted,
                            pin_ready: out_pin_ready, pin_value: out_pin_value,
                            beep_on: out_beep_on, entry_position: out_entry_position});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic cmd, input logic [1:0] col, input logic [2:0] row);
    bit taken;
    taken = 1'b0;
    @(negedge clk);
    while (!steady_flow && $urandom_range(0, 99) < 30) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    in_cmd    = cmd;
    in_column = col;
    in_row    = row;
    while (!taken) begin
      @(posedge clk);
      if (in_ready) begin
        taken = 1'b1;
        pin_sb.note_request(cmd, col, row);
      end
    end
  endtask

  task automatic press(input logic [1:0] col, input logic [2:0] row);
    send_request(kpe_pkg::CMD_KEY, col, row);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pin_sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [kpe_pkg::CfgIdxWidth-1:0] idx,
                                input logic [kpe_pkg::CfgWidth-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    pin_sb.write_register(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_random(input int count);
    int         pick;
    logic [1:0] col;
    logic [2:0] row;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      col  = 2'($urandom_range(1, 3));
      row  = 3'($urandom_range(1, 4));
      if (pick < 35) begin
        send_request(kpe_pkg::CMD_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      end else if (pick < 55) begin
        press(prev_col, prev_row);
      end else if (pick < 62) begin
        col = 2'($urandom_range(0, 3));
        row = 3'($urandom_range(0, 7));
        if (col != 0 && row >= 1 && row <= 4) row = 3'(5 + $urandom_range(0, 2));
        press(col, row);
      end else begin
        if (pick < 70) begin
          col = 2'd3;
          row = 3'd1;
        end else if (pick < 74) begin
          col = 2'd1;
          row = 3'd1;
        end
        prev_col = col;
        prev_row = row;
        press(col, row);
      end
    end
  endtask

  task automatic run_phase(input logic [kpe_pkg::CfgWidth-1:0] guard,
                           input logic [kpe_pkg::CfgWidth-1:0] beep,
                           input logic [kpe_pkg::CfgWidth-1:0] clear, input int count);
    write_register(kpe_pkg::REG_REPEAT_GUARD, guard);
    write_register(kpe_pkg::REG_BEEP_KEY, beep);
    write_register(kpe_pkg::REG_BEEP_CLEAR, clear);
    send_random(count);
    drain();
  endtask

  initial begin
    pin_sb        = new();
    steady_flow   = 1'b0;
    hold_requests = 0;
    prev_col      = 2'd2;
    prev_row      = 3'd4;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = kpe_pkg::CMD_TICK;
    in_column     = '0;
    in_row        = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(kpe_pkg::CMD_TICK, 2'd0, 3'd0);
    press(2'd1, 3'd4);
    press(2'd1, 3'd4);
    press(2'd2, 3'd4);
    press(2'd3, 3'd4);
    press(2'd1, 3'd3);
    press(2'd2, 3'd3);
    press(2'd3, 3'd1);
    press(2'd3, 3'd1);
    press(2'd3, 3'd3);
    press(2'd1, 3'd2);
    press(2'd2, 3'd2);
    press(2'd3, 3'd2);
    press(2'd1, 3'd1);
    press(2'd1, 3'd1);
    press(2'd0, 3'd1);
    press(2'd3, 3'd0);
    press(2'd1, 3'd5);
    press(2'd2, 3'd7);
    press(2'd3, 3'd6);
    send_request(kpe_pkg::CMD_TICK, 2'd3, 3'd7);
    press(2'd2, 3'd1);
    press(2'd3, 3'd2);
    press(2'd3, 3'd1);
    drain();

    write_register(RegUnused, 16'hFFFF);
    hold_requests = 1;
    run_phase(16'd3, 16'd2, 16'd6, 200);
    run_phase(16'd0, 16'd0, 16'd0, 100);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 100);
    steady_flow = 1'b1;
    run_phase(16'd1, 16'd1, 16'd1, 150);
    steady_flow = 1'b0;
    for (int p = 0; p < 3; p++)
      run_phase(16'($urandom_range(0, 12)), 16'($urandom_range(0, 8)),
                16'($urandom_range(0, 20)), 150);
    hold_requests = 2;
    run_phase(16'd5, 16'd3, 16'd9, 100);

    if (pin_sb.failures == 0 && pin_sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/kpe_pkg.sv
hdl/keypad_pin_entry_unit.sv
bench/tb_keypad_pin_entry_unit.sv
